// File: rtl/lsfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame builder package
// Shared types and constants for the command front end and the frame engine.
// ----------------------------------------------------------------------------
package lsfb_pkg;

   // Widest LED address the design supports (up to 64 LEDs).
   localparam int LED_ADDR_W = 6;

   localparam logic [2:0]  HEADER_MARK = 3'b111;
   localparam logic [31:0] START_WORD  = 32'h0000_0000;
   localparam logic [31:0] END_WORD    = 32'hFFFF_FFFF;

   // One classified command as it travels from the front end to the engine.
   typedef struct packed {
      logic                  set_all;   // index zero: every LED takes the word
      logic                  hit;       // index names one LED of the strip
      logic [LED_ADDR_W-1:0] led_addr;  // zero-based LED address when hit is set
      logic [31:0]           word;      // header, brightness, blue, green, red
   } cmd_type;

endpackage

// File: rtl/led_strip_frame_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame builder
// Keeps one 32-bit word per LED and, for every command, streams the whole
// strip frame: a start word of zeros, one word per LED and an end word of ones.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid / req_stall  led_index, brightness, blue,
//                                                green, red
//   rsp_      out         rsp_valid / rsp_stall  frame_word, last_word
//
// Each command transaction yields LED_COUNT + 2 response transactions, one
// per cycle while the response side does not stall; the frame engine sets
// this figure, issuing one frame word a cycle through the LED store's single
// read port. Queued commands follow each other without a gap.
// Reset is synchronous and active high. It empties both queues and marks
// every LED word as unwritten, which reads back as all ones; no clearing
// pass is needed.
// A stall on the response side backs up the output queue, then the engine,
// then the two-entry command queue, and finally raises req_stall.
//
// Index zero writes the word to every LED, indexes one to LED_COUNT write a
// single LED, and any higher index leaves the store untouched while the
// frame is still sent. The LED word is 3'b111, the 5-bit brightness, then
// blue, green and red. Store updates are made while the frame streams past
// each LED, so the frame always shows the store after the command.
// ----------------------------------------------------------------------------
module led_strip_frame_builder_top
   import lsfb_pkg::*;
#(
   parameter int LED_COUNT = 60
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_led_index,
   input  logic [4:0]    req_brightness,
   input  logic [7:0]    req_blue,
   input  logic [7:0]    req_green,
   input  logic [7:0]    req_red,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [31:0]   rsp_frame_word,
   output logic          rsp_last_word
);

   // Classified command handed from the front end to the frame engine.
   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   lsfb_front #(
      .LED_COUNT (LED_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_led_index  (req_led_index),
      .req_brightness (req_brightness),
      .req_blue       (req_blue),
      .req_green      (req_green),
      .req_red        (req_red),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd)
   );

   // The engine owns the LED store and the output queue.
   lsfb_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_take       (cmd_take),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_word (rsp_frame_word),
      .rsp_last_word  (rsp_last_word)
   );

endmodule

// File: rtl/lsfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame builder front end
// Accepts commands, classifies the LED index and builds the LED word, then
// holds them in a two-entry queue for the frame engine.
// ----------------------------------------------------------------------------
module lsfb_front
   import lsfb_pkg::*;
#(
   parameter int LED_COUNT = 60
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_led_index,
   input  logic [4:0]    req_brightness,
   input  logic [7:0]    req_blue,
   input  logic [7:0]    req_green,
   input  logic [7:0]    req_red,
   output logic          cmd_valid,
   input  logic          cmd_take,
   output cmd_type       cmd
);

   cmd_type    cmd_q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    new_cmd;
   logic       push;
   logic       pop;

   always_comb begin
      new_cmd.set_all  = (req_led_index == 8'd0);
      new_cmd.hit      = (req_led_index != 8'd0) && (req_led_index <= 8'(LED_COUNT));
      new_cmd.led_addr = LED_ADDR_W'(req_led_index - 8'd1);
      new_cmd.word     = {HEADER_MARK, req_brightness, req_blue, req_green, req_red};
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = cmd_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   // The queue occupancy can never pass its two entries.
   a_cmd_q_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("command queue occupancy out of range");

endmodule

// File: rtl/lsfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip frame builder engine
// Applies a command to the LED store while streaming the frame: start word,
// one word per LED, end word. Words pass through a two-entry output queue.
// ----------------------------------------------------------------------------
module lsfb_back
   import lsfb_pkg::*;
#(
   parameter int LED_COUNT = 60
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   output logic          cmd_take,
   input  cmd_type       cmd,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [31:0]   rsp_frame_word,
   output logic          rsp_last_word
);

   localparam int AddrW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int PosW  = $clog2(LED_COUNT + 2);
   localparam int CmpW  = 8;

   typedef enum logic {
      ST_IDLE,
      ST_STREAM
   } state_type;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } oq_entry_type;

   state_type    state_ff, state_in;
   logic [PosW-1:0] pos_ff, pos_in;
   cmd_type      cur_ff, cur_in;

   // Word issued last cycle, waiting for the store read data.
   logic         pend_ff, pend_in;
   logic         pend_mem_ff, pend_mem_in;
   logic         pend_vld_ff, pend_vld_in;
   logic [31:0]  pend_word_ff, pend_word_in;
   logic         pend_last_ff, pend_last_in;

   oq_entry_type oq_ff [2];
   logic         oq_wr_ff, oq_wr_in;
   logic         oq_rd_ff, oq_rd_in;
   logic [1:0]   oq_cnt_ff, oq_cnt_in;

   logic [31:0]  store_ff [LED_COUNT];
   logic [LED_COUNT-1:0] led_vld_ff;
   logic [31:0]  rd_data_ff;

   logic [PosW-1:0]  led_sel;
   logic [AddrW-1:0] led_idx;
   logic         is_start;
   logic         is_end;
   logic         led_hit;
   logic         can_issue;
   logic         issue;
   logic         mem_wr;
   logic         oq_push;
   logic         oq_pop;
   oq_entry_type push_entry;

   always_comb begin
      led_sel  = pos_ff - PosW'(1);
      led_idx  = led_sel[AddrW-1:0];
      is_start = (pos_ff == '0);
      is_end   = (pos_ff == PosW'(LED_COUNT + 1));
      led_hit  = cur_ff.set_all ||
                 (cur_ff.hit && (CmpW'(cur_ff.led_addr) == CmpW'(led_sel)));
      oq_pop   = rsp_valid && !rsp_stall;
      can_issue = ({1'b0, oq_cnt_ff} + {2'b00, pend_ff}) <= (3'd1 + {2'b00, oq_pop});
      issue    = (state_ff == ST_STREAM) && can_issue;
      mem_wr   = issue && !is_start && !is_end && led_hit;
      cmd_take = (state_ff == ST_IDLE) || (issue && is_end);
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      pend_in      = issue;
      pend_mem_in  = 1'b0;
      pend_vld_in  = 1'b0;
      pend_word_in = pend_word_ff;
      pend_last_in = 1'b0;

      if (issue) begin
         if (is_start) begin
            pend_word_in = START_WORD;
         end else if (is_end) begin
            pend_word_in = END_WORD;
            pend_last_in = 1'b1;
         end else if (led_hit) begin
            pend_word_in = cur_ff.word;
         end else begin
            pend_mem_in = 1'b1;
            pend_vld_in = led_vld_ff[led_idx];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cur_in   = cmd;
               pos_in   = '0;
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            if (issue) begin
               if (is_end) begin
                  // Chain straight into the next queued command.
                  pos_in = '0;
                  if (cmd_valid) begin
                     cur_in = cmd;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  pos_in = pos_ff + PosW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      oq_push         = pend_ff;
      push_entry.word = pend_mem_ff ? (pend_vld_ff ? rd_data_ff : END_WORD) : pend_word_ff;
      push_entry.last = pend_last_ff;
      oq_wr_in        = oq_push ? ~oq_wr_ff : oq_wr_ff;
      oq_rd_in        = oq_pop ? ~oq_rd_ff : oq_rd_ff;
      oq_cnt_in       = oq_cnt_ff + {1'b0, oq_push} - {1'b0, oq_pop};
   end

   assign rsp_valid      = (oq_cnt_ff != 2'd0);
   assign rsp_frame_word = oq_ff[oq_rd_ff].word;
   assign rsp_last_word  = oq_ff[oq_rd_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         pend_ff   <= 1'b0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         pend_mem_ff  <= pend_mem_in;
         pend_vld_ff  <= pend_vld_in;
         pend_word_ff <= pend_word_in;
         pend_last_ff <= pend_last_in;
         oq_wr_ff     <= oq_wr_in;
         oq_rd_ff     <= oq_rd_in;
         oq_cnt_ff    <= oq_cnt_in;
         if (oq_push) begin
            oq_ff[oq_wr_ff] <= push_entry;
         end
      end
   end

   // LED store: one write and one registered read per cycle. An entry never
   // written since reset reads as all ones through its valid bit.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store_ff[led_idx] <= cur_ff.word;
      end
      rd_data_ff <= store_ff[led_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_vld_ff <= '0;
      end else if (mem_wr) begin
         led_vld_ff[led_idx] <= 1'b1;
      end
   end

   a_oq_credit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, oq_cnt_ff} + {2'b00, pend_ff}) <= 3'd2)
      else $error("output queue over-committed");

   a_end_word_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |-> rsp_frame_word == END_WORD)
      else $error("last word is not the end word");

   a_pend_from_stream: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == ST_STREAM))
      else $error("word issued outside a frame");

endmodule
